// ----- rtl/smith_ggx_geometry_term_defines.svh -----
// assertion macros for the smith ggx geometry term top level
// expects clk and rst_n in the scope where a macro is used
`ifndef SMITH_GGX_GEOMETRY_TERM_DEFINES_SVH
`define SMITH_GGX_GEOMETRY_TERM_DEFINES_SVH

// consequent checked in the same cycle
`define SGGX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define SGGX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sggx_pkg.sv -----
// types, widths and pipeline stage numbers for the smith ggx geometry term
// no dependencies
package sggx_pkg;

    localparam int COMPONENT_WIDTH = 16;

    // clamped dot product, unsigned q.14, at most 3 * 2^16
    localparam int D_W      = 18;
    localparam int R_W      = 16;
    localparam int K_W      = 32;
    localparam int OMK_W    = 33;
    localparam int PROD_W   = 52;
    localparam int DEN_W    = 53;
    localparam int FACTOR_W = 16;
    localparam int SAT_SH   = 30;

    localparam logic [R_W-1:0]   ROUGHNESS_RESET = 16'd16384;
    localparam logic [K_W-1:0]   K_RESET         = 32'h1000_0000;
    localparam logic [OMK_W-1:0] OMK_ONE         = 33'h0_8000_0000;
    localparam logic [OMK_W-1:0] OMK_RESET       = 33'h0_7000_0000;

    // pipeline stage numbers
    localparam int ST_PROD    = 0;
    localparam int ST_DOT     = 1;
    localparam int ST_MUL     = 2;
    localparam int ST_DEN     = 3;
    localparam int ST_CHK     = 4;
    localparam int ST_DIV0    = 5;
    localparam int DIV_STEPS  = FACTOR_W;
    localparam int ST_GEO     = ST_DIV0 + DIV_STEPS;
    localparam int NUM_STAGES = ST_GEO + 1;

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
    typedef logic [NUM_STAGES-1:0] stage_en_t;

    typedef struct packed {
        comp_t normal_x;
        comp_t normal_y;
        comp_t normal_z;
        comp_t view_x;
        comp_t view_y;
        comp_t view_z;
        comp_t light_x;
        comp_t light_y;
        comp_t light_z;
    } vec_item_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] geometry_term;
        logic [FACTOR_W-1:0] view_factor;
        logic [FACTOR_W-1:0] light_factor;
        logic                zero_denominator;
    } geo_item_t;

endpackage

// ----- rtl/sggx_lane.sv -----
// one schlick-ggx factor: denominator, range checks and a 16-step restoring divider
// depends on sggx_pkg; stage enables come from the top level
module sggx_lane (
    input  logic                                   clk,
    input  sggx_pkg::stage_en_t                    en,
    input  logic [sggx_pkg::D_W-1:0]               d,
    input  logic [sggx_pkg::K_W-1:0]               k,
    input  logic signed [sggx_pkg::OMK_W-1:0]      omk,
    output logic [sggx_pkg::FACTOR_W-1:0]          factor,
    output logic                                   zero_den
);

    localparam int DW    = sggx_pkg::DEN_W;
    localparam int NS    = sggx_pkg::DIV_STEPS;
    localparam int PAD_W = DW - sggx_pkg::D_W - sggx_pkg::SAT_SH;

    logic signed [sggx_pkg::PROD_W-1:0] prod_reg;
    logic [sggx_pkg::D_W-1:0]           d2_reg;
    logic [DW-1:0]                      den_reg;
    logic [sggx_pkg::D_W-1:0]           d3_reg;
    logic [DW-1:0]                      rem0_next;

    logic [DW-1:0]                    rem_reg  [0:NS];
    logic [DW-1:0]                    dv_reg   [0:NS];
    logic [sggx_pkg::FACTOR_W-1:0]    q_reg    [0:NS];
    logic                             zero_reg [0:NS];
    logic                             kill_reg [0:NS];
    logic                             sat_reg  [0:NS];

    always_ff @(posedge clk)
    begin
        if (en[sggx_pkg::ST_MUL])
        begin
            prod_reg <= $signed({1'b0, d}) * omk;
            d2_reg   <= d;
        end
        if (en[sggx_pkg::ST_DEN])
        begin
            den_reg <= {prod_reg[sggx_pkg::PROD_W-1], prod_reg} + {7'b0, k, 14'b0};
            d3_reg  <= d2_reg;
        end
    end

    assign rem0_next = {{PAD_W{1'b0}}, d3_reg, {sggx_pkg::SAT_SH{1'b0}}};

    // a quotient of 2^16 or more shows up as d * 2^30 >= den
    always_ff @(posedge clk)
    begin
        if (en[sggx_pkg::ST_CHK])
        begin
            rem_reg[0]  <= rem0_next;
            dv_reg[0]   <= den_reg;
            q_reg[0]    <= '0;
            zero_reg[0] <= (den_reg == '0);
            kill_reg[0] <= den_reg[DW-1] || (den_reg == '0);
            sat_reg[0]  <= rem0_next >= den_reg;
        end
    end

    genvar j;
    generate
        for (j = 0; j < NS; j++)
        begin : g_step
            logic [DW-1:0] r2;
            logic          ge;

            assign r2 = {rem_reg[j][DW-2:0], 1'b0};
            assign ge = r2 >= dv_reg[j];

            always_ff @(posedge clk)
            begin
                if (en[sggx_pkg::ST_DIV0 + j])
                begin
                    rem_reg[j+1]  <= ge ? (r2 - dv_reg[j]) : r2;
                    q_reg[j+1]    <= {q_reg[j][sggx_pkg::FACTOR_W-2:0], ge};
                    dv_reg[j+1]   <= dv_reg[j];
                    zero_reg[j+1] <= zero_reg[j];
                    kill_reg[j+1] <= kill_reg[j];
                    sat_reg[j+1]  <= sat_reg[j];
                end
            end
        end
    endgenerate

    assign factor   = kill_reg[NS] ? '0 : (sat_reg[NS] ? '1 : q_reg[NS]);
    assign zero_den = zero_reg[NS];

endmodule

// ----- rtl/smith_ggx_geometry_term.sv -----
// channel  | handshake          | payload
// in       | in_valid/in_stall  | in_data  (normal, view, light vectors)
// out      | out_valid/out_stall| out_data (geometry term, both factors, flag)
// cfg      | cfg_we             | cfg_wdata (roughness)
// 22 register stages: products, dot, multiply, denominator, checks, 16 divider steps, product
// one transaction per cycle unless out_stall holds the pipeline; one quotient bit per divider stage
// reset clears the stage valid bits and sets roughness to 0.5
// a stall only holds stages that are full; empty stages keep filling behind it
// a roughness write reaches k through roughness_reg and k_reg, and 1 - k through omk_reg after them
// top level; depends on sggx_pkg, sggx_lane and the assertion macro header
`include "smith_ggx_geometry_term_defines.svh"

module smith_ggx_geometry_term (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sggx_pkg::vec_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sggx_pkg::geo_item_t   out_data,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_wdata
);

    localparam int W     = sggx_pkg::COMPONENT_WIDTH;
    localparam int PW    = 2 * W;
    localparam int SUM_W = 2 * W + 2;
    localparam int SH    = 2 * W - 18;
    localparam int LSH   = (SH < 0) ? -SH : 0;
    localparam int RSH   = (SH > 0) ? SH : 0;
    localparam int SC_W  = SUM_W + LSH;
    localparam int NS    = sggx_pkg::NUM_STAGES;
    localparam int FW    = sggx_pkg::FACTOR_W;

    logic [sggx_pkg::R_W-1:0]          roughness_reg;
    logic [sggx_pkg::K_W-1:0]          k_reg;
    logic signed [sggx_pkg::OMK_W-1:0] omk_reg;

    logic [NS-1:0]       vld_reg;
    sggx_pkg::stage_en_t en;

    sggx_pkg::comp_t     n_c [0:2];
    sggx_pkg::comp_t     v_c [0:2];
    sggx_pkg::comp_t     l_c [0:2];
    logic signed [PW-1:0] pv_reg [0:2];
    logic signed [PW-1:0] pl_reg [0:2];

    logic [sggx_pkg::D_W-1:0] dv_reg;
    logic [sggx_pkg::D_W-1:0] dl_reg;

    logic [FW-1:0]       fv;
    logic [FW-1:0]       fl;
    logic                zv;
    logic                zl;
    logic [2*FW-1:0]     gp;
    sggx_pkg::geo_item_t out_reg;

    function automatic logic [sggx_pkg::D_W-1:0] clamp_dot(
        input logic signed [PW-1:0] a,
        input logic signed [PW-1:0] b,
        input logic signed [PW-1:0] c
    );
        logic signed [SUM_W-1:0] s;
        logic [SC_W-1:0]         sc;
        s  = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
        sc = SC_W'($unsigned(s)) << LSH;
        sc = sc >> RSH;
        if (s[SUM_W-1] || (s == '0))
            return '0;
        return sc[sggx_pkg::D_W-1:0];
    endfunction

    // configuration, k and 1 - k follow the register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roughness_reg <= sggx_pkg::ROUGHNESS_RESET;
            k_reg         <= sggx_pkg::K_RESET;
            omk_reg       <= $signed(sggx_pkg::OMK_RESET);
        end
        else
        begin
            if (cfg_we)
                roughness_reg <= cfg_wdata;
            k_reg   <= sggx_pkg::K_W'(roughness_reg * roughness_reg);
            omk_reg <= $signed(sggx_pkg::OMK_ONE - {1'b0, k_reg});
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign n_c[0] = in_data.normal_x;
    assign n_c[1] = in_data.normal_y;
    assign n_c[2] = in_data.normal_z;
    assign v_c[0] = in_data.view_x;
    assign v_c[1] = in_data.view_y;
    assign v_c[2] = in_data.view_z;
    assign l_c[0] = in_data.light_x;
    assign l_c[1] = in_data.light_y;
    assign l_c[2] = in_data.light_z;

    always_ff @(posedge clk)
    begin
        if (en[sggx_pkg::ST_PROD])
            for (int i = 0; i < 3; i++)
            begin
                pv_reg[i] <= n_c[i] * v_c[i];
                pl_reg[i] <= n_c[i] * l_c[i];
            end
        if (en[sggx_pkg::ST_DOT])
        begin
            dv_reg <= clamp_dot(pv_reg[0], pv_reg[1], pv_reg[2]);
            dl_reg <= clamp_dot(pl_reg[0], pl_reg[1], pl_reg[2]);
        end
    end

    sggx_lane u_view (
        .clk      (clk),
        .en       (en),
        .d        (dv_reg),
        .k        (k_reg),
        .omk      (omk_reg),
        .factor   (fv),
        .zero_den (zv)
    );

    sggx_lane u_light (
        .clk      (clk),
        .en       (en),
        .d        (dl_reg),
        .k        (k_reg),
        .omk      (omk_reg),
        .factor   (fl),
        .zero_den (zl)
    );

    assign gp = fv * fl;

    always_ff @(posedge clk)
    begin
        if (en[sggx_pkg::ST_GEO])
        begin
            out_reg.geometry_term    <= gp[2*FW-1] ? '1 : gp[2*FW-2:FW-1];
            out_reg.view_factor      <= fv;
            out_reg.light_factor     <= fl;
            out_reg.zero_denominator <= zv || zl;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_data  = out_reg;

    `SGGX_ASSERT_SAME(a_flag_zero, out_valid && out_data.zero_denominator,
        out_data.geometry_term == '0, "zero denominator with non-zero geometry term")
    `SGGX_ASSERT_SAME(a_factor_zero,
        out_valid && (out_data.view_factor == '0 || out_data.light_factor == '0),
        out_data.geometry_term == '0, "zero factor with non-zero geometry term")
    `SGGX_ASSERT_SAME(a_full_stall, out_valid && out_stall && (&vld_reg),
        in_stall, "input taken while the pipeline is full and stalled")
    `SGGX_ASSERT_SAME(a_empty_take, !vld_reg[0], !in_stall,
        "input stalled with an empty first stage")
    `SGGX_ASSERT_NEXT(a_enter, in_valid && !in_stall, vld_reg[0],
        "accepted transaction missing from the first stage")

endmodule

// ----- dv/smith_ggx_geometry_term_checker.sv -----
// transaction checker for the smith ggx geometry term: predicts each result
// from the input transactions and the roughness setting; depends on sggx_pkg
module smith_ggx_geometry_term_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  sggx_pkg::vec_item_t in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  sggx_pkg::geo_item_t out_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    output int                  fail_count,
    output int                  pending_count,
    output int                  flag_count
);

    logic [15:0]         rough_model;
    sggx_pkg::geo_item_t expected_geo[$];

    // clamped dot product reduced to unsigned q.14 by truncation
    function automatic longint clamped_dot(
        sggx_pkg::comp_t a0, sggx_pkg::comp_t a1, sggx_pkg::comp_t a2,
        sggx_pkg::comp_t b0, sggx_pkg::comp_t b1, sggx_pkg::comp_t b2);
        longint total;
        total = longint'(a0) * longint'(b0) + longint'(a1) * longint'(b1)
              + longint'(a2) * longint'(b2);
        if (total <= 0)
            return 0;
        return total >>> 14;
    endfunction

    function automatic logic [15:0] ggx_g1(longint d, logic [15:0] r, ref logic zflag);
        longint     k;
        longint     den;
        logic [63:0] q;
        k   = longint'(r) * longint'(r);
        den = d * ((64'sd1 <<< 31) - k) + k * 16384;
        if (den == 0)
        begin
            zflag = 1'b1;
            return 16'd0;
        end
        if (den < 0)
            return 16'd0;
        // unsigned division, the shifted numerator can reach bit 63
        q = (64'($unsigned(d)) << 46) / 64'($unsigned(den));
        return (q > 65535) ? 16'hffff : q[15:0];
    endfunction

    function automatic sggx_pkg::geo_item_t predict_geometry(sggx_pkg::vec_item_t v,
                                                             logic [15:0] r);
        sggx_pkg::geo_item_t g;
        logic                zflag;
        logic [31:0]         prod;
        zflag = 1'b0;
        g.view_factor  = ggx_g1(clamped_dot(v.normal_x, v.normal_y, v.normal_z,
                                            v.view_x, v.view_y, v.view_z), r, zflag);
        g.light_factor = ggx_g1(clamped_dot(v.normal_x, v.normal_y, v.normal_z,
                                            v.light_x, v.light_y, v.light_z), r, zflag);
        prod = (32'(g.view_factor) * 32'(g.light_factor)) >> 15;
        g.geometry_term    = (prod > 65535) ? 16'hffff : prod[15:0];
        g.zero_denominator = zflag;
        return g;
    endfunction

    assign pending_count = expected_geo.size();

    always @(posedge clk or negedge rst_n)
    begin
        sggx_pkg::geo_item_t e;
        if (!rst_n)
        begin
            rough_model <= sggx_pkg::ROUGHNESS_RESET;
            fail_count  <= 0;
            flag_count  <= 0;
            expected_geo.delete();
        end
        else
        begin
            if (cfg_we)
                rough_model <= cfg_wdata;
            if (in_valid && !in_stall)
                expected_geo.push_back(predict_geometry(in_data, rough_model));
            if (out_valid && !out_stall)
            begin
                if (expected_geo.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_geo.pop_front();
                    if (out_data.zero_denominator)
                        flag_count <= flag_count + 1;
                    if (e !== out_data)
                    begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, e, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- dv/tb_smith_ggx_geometry_term.sv -----
// stimulus and verdict for the smith ggx geometry term
// depends on sggx_pkg, the block and smith_ggx_geometry_term_checker
module tb_smith_ggx_geometry_term;

    localparam int LATENCY = 22;
    localparam int LIMIT   = 400000;
    localparam logic [15:0] ROUGH_LIST [6] =
        '{16'd0, 16'd32768, 16'd65535, 16'd1, 16'd8000, 16'd46341};

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    sggx_pkg::vec_item_t in_data;
    logic                out_valid;
    logic                out_stall = 1'b0;
    sggx_pkg::geo_item_t out_data;
    logic                cfg_we;
    logic [15:0]         cfg_wdata;
    int                  fail_count;
    int                  pending_count;
    int                  flag_count;
    int                  cycle_count = 0;
    int                  sent_count;
    int                  send_idle;
    int                  stall_pct;

    smith_ggx_geometry_term i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    smith_ggx_geometry_term_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .flag_count(flag_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        out_stall   <= ($urandom_range(99) < stall_pct);
        if (cycle_count > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic sggx_pkg::comp_t rand_comp();
        case ($urandom_range(5))
            0: return sggx_pkg::comp_t'(16'h8000);
            1: return sggx_pkg::comp_t'(16'h7fff);
            2: return sggx_pkg::comp_t'(16'h4000);
            3: return sggx_pkg::comp_t'($signed(16'(int'($urandom_range(600)) - 300)));
            default: return sggx_pkg::comp_t'($urandom);
        endcase
    endfunction

    function automatic sggx_pkg::vec_item_t rand_vec();
        sggx_pkg::vec_item_t v;
        v = '{rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
              rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        // some unit-ish vectors with random sign to reach both clamp sides
        if ($urandom_range(2) == 0)
        begin
            v.normal_x = '0; v.normal_y = '0; v.normal_z = 16'sh4000;
            v.view_z   = sggx_pkg::comp_t'($signed(16'($urandom_range(32768) - 16384)));
            v.light_z  = sggx_pkg::comp_t'($signed(16'($urandom_range(32768) - 16384)));
        end
        return v;
    endfunction

    // one transaction, held until accepted, with random leading idle cycles
    task automatic send_item(sggx_pkg::vec_item_t v);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_roughness(logic [15:0] r);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
        repeat (3) @(posedge clk);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle = idle;
        stall_pct = stall;
        repeat (n) send_item(rand_vec());
    endtask

    initial
    begin
        sggx_pkg::vec_item_t v;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        sent_count  = 0;
        send_idle   = 0;
        stall_pct   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: aligned, opposite, orthogonal, extremes, at reset and at zero roughness
        for (int pass = 0; pass < 2; pass++)
        begin
            v = '{0, 0, 16'sh4000, 0, 0, 16'sh4000, 0, 0, 16'sh4000};
            send_item(v);
            v.view_z = -16'sh4000; send_item(v);
            v.view_z = 0; v.view_x = 16'sh4000; send_item(v);
            send_item('{default: 16'sh7fff});
            send_item('{default: -16'sh8000});
            send_item('{-16'sh8000, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff,
                        16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000});
            v = '{0, 0, 16'sh4000, 0, 0, 16'sh0001, 0, 0, 16'sh0002};
            send_item(v);
            send_item('{0, 0, 16'sh0001, 0, 0, 16'sh0001, 0, 0, 16'sh0004});
            send_item('0);
            send_item('{16'shffff, 16'shaaaa, 16'sh5555, 16'shffff, 16'sh5555,
                        16'shaaaa, 16'sh1234, 16'shedcb, 16'sh0f0f});
            if (pass == 0)
                write_roughness(16'd0);
        end
        // above 1.0 roughness: negative and cancelling denominators
        write_roughness(16'd65535);
        send_item('{0, 0, 16'sh4000, 0, 0, 16'sh7fff, 0, 0, 16'sh0100});

        for (int p = 0; p < 6; p++)
        begin
            write_roughness(ROUGH_LIST[p]);
            random_phase(30, 0, 0);
            random_phase(30, 81, 0);
            random_phase(30, 0, 81);
            random_phase(30, 18, 18);
        end
        write_roughness(16'($urandom));
        random_phase(60, 0, 0);
        // hold off until everything expected has come back
        drain();
        random_phase(40, 18, 18);

        stall_pct = 0;
        drain();
        repeat (6) @(posedge clk);
        $display("sent %0d transactions across several roughness settings, %0d results flagged",
                 sent_count, flag_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- smith_ggx_geometry_term.f -----
+incdir+rtl
rtl/sggx_pkg.sv
rtl/sggx_lane.sv
rtl/smith_ggx_geometry_term.sv
dv/smith_ggx_geometry_term_checker.sv
dv/tb_smith_ggx_geometry_term.sv
